// ===== hdl/scm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, register map and defaults of the spectral compressor mask.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned NumBinsDef = 257;

  localparam int unsigned GainW  = 24;  // Q8.16 gains, Q2.21 bins
  localparam int unsigned DecayW = 16;  // Q0.16 decays
  localparam int unsigned IdxW   = 12;
  localparam int unsigned WideW  = 48;  // squares, level
  localparam int unsigned ProdW  = WideW + GainW;
  localparam int unsigned QuotW  = 38;  // 2^37 / magnitude

  localparam logic [GainW-1:0]  Max24          = 24'hFF_FFFF;
  localparam logic [GainW-1:0]  PreEqGainRst   = 24'd65536;
  localparam logic [DecayW-1:0] MeterDecayRst  = 16'd65000;
  localparam logic [DecayW-1:0] DisplayDecayRst = 16'd60000;

  typedef enum logic [1:0] {
    REG_EQ_ENABLE     = 2'd0,
    REG_PRE_EQ_GAIN   = 2'd1,
    REG_METER_DECAY   = 2'd2,
    REG_DISPLAY_DECAY = 2'd3
  } reg_idx_e;

endpackage
`default_nettype wire

// ===== hdl/spectral_compressor_mask.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_compressor_mask
// Per-bin compression mask with level peak and per-bin reduction peaks.
// ----------------------------------------------------------------------------
// channel  | dir | width | contents
// s_axis   | in  | 112   | bin index, real, imag, comp gain, eq gain; tlast
// m_axis   | out | 88    | index, mask, reduction peak, level peak; tlast
// apb      | in  | 32    | eq_enable, pre_eq_gain, meter_decay, display_decay
//
// Each bin is worked through one shared bit-serial multiplier, a square root
// unit and, when the bin is limited, a divider. After reset a clearing pass
// over all NUM_BINS entries zeroes the reduction peak memory; no request is
// taken meanwhile. A stalled result waits in the output register while the
// next bin is processed.
// ----------------------------------------------------------------------------
module spectral_compressor_mask #(
  parameter int unsigned NUM_BINS = scm_pkg::NumBinsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bin_index[11:0], bin_real[35:12], bin_imag[59:36], comp_gain[83:60],
  // eq_gain[107:84], zero pad
  input  wire logic [111:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_index[11:0], mask_gain[35:12], reduction_peak[59:36],
  // level_peak[83:60], zero pad
  output logic      [87:0]  m_axis_tdata,
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned GW = scm_pkg::GainW;
  localparam int unsigned DW = scm_pkg::DecayW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQ_RE, ST_SQ_IM, ST_ROOT, ST_LEVEL, ST_DIVIDE,
    ST_PEAK, ST_REDUCE, ST_EQ1, ST_EQ2, ST_OUT
  } state_e;

  // configuration
  logic          eq_en_q;
  logic [GW-1:0] pre_eq_q;
  logic [DW-1:0] meter_decay_q, disp_decay_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_en_q       <= 1'b0;
      pre_eq_q      <= scm_pkg::PreEqGainRst;
      meter_decay_q <= scm_pkg::MeterDecayRst;
      disp_decay_q  <= scm_pkg::DisplayDecayRst;
    end else if (cfg_wr) begin
      unique case (scm_pkg::reg_idx_e'(paddr[3:2]))
        scm_pkg::REG_EQ_ENABLE:     eq_en_q       <= pwdata[0];
        scm_pkg::REG_PRE_EQ_GAIN:   pre_eq_q      <= pwdata[GW-1:0];
        scm_pkg::REG_METER_DECAY:   meter_decay_q <= pwdata[DW-1:0];
        scm_pkg::REG_DISPLAY_DECAY: disp_decay_q  <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (scm_pkg::reg_idx_e'(paddr[3:2]))
      scm_pkg::REG_EQ_ENABLE:     prdata = {31'b0, eq_en_q};
      scm_pkg::REG_PRE_EQ_GAIN:   prdata = {8'b0, pre_eq_q};
      scm_pkg::REG_METER_DECAY:   prdata = {16'b0, meter_decay_q};
      scm_pkg::REG_DISPLAY_DECAY: prdata = {16'b0, disp_decay_q};
      default:                    prdata = '0;
    endcase
  end

  // datapath state
  state_e                       state_q;
  logic                         st_q;      // unit started in this state
  logic [AW-1:0]                clr_q;
  logic [scm_pkg::IdxW-1:0]     idx_q;
  logic [GW-1:0]                re_q, im_q, comp_q, eq_q, mag_q, cmask_q;
  logic [GW-1:0]                peak_q, rpeak_q, mask_q;
  logic                         last_q;
  logic [scm_pkg::WideW-1:0]    sq_q, level_q, t_q;

  logic                         ovalid_q, olast_q;
  logic [scm_pkg::IdxW-1:0]     oidx_q;
  logic [GW-1:0]                omask_q, orpeak_q, opeak_q;

  // units
  logic                         mul_start, mul_done;
  logic [scm_pkg::WideW-1:0]    mul_a;
  logic [GW-1:0]                mul_b;
  logic [scm_pkg::ProdW-1:0]    mul_p;
  logic                         sqrt_start, sqrt_done;
  logic [GW-1:0]                sqrt_root;
  logic                         div_start, div_done;
  logic [scm_pkg::QuotW-1:0]    div_q;

  // reduction peak memory
  logic [GW-1:0]                mem_q [NUM_BINS];
  logic [GW-1:0]                rd_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [GW-1:0]                mem_wd;

  logic [GW-1:0]                re_abs, im_abs, red, decayed;
  logic                         in_range, red_up, peak_up, limit, need_mul;
  logic [scm_pkg::ProdW-1:0]    eq_full;
  logic                         out_load;

  assign re_abs = s_axis_tdata[35] ? GW'(24'd0 - s_axis_tdata[35:12])
                                   : s_axis_tdata[35:12];
  assign im_abs = s_axis_tdata[59] ? GW'(24'd0 - s_axis_tdata[59:36])
                                   : s_axis_tdata[59:36];

  assign in_range = (32'(idx_q) < NUM_BINS);
  assign red      = (comp_q > cmask_q) ? GW'(comp_q - cmask_q) : '0;
  assign red_up   = red > rd_q;
  assign peak_up  = level_q > {3'b0, peak_q, 21'b0};
  assign limit    = (level_q > (48'd1 << 37)) && (mag_q != '0);
  assign decayed  = mul_p[GW+15:16];
  assign eq_full  = mul_p;

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    need_mul = 1'b0;
    unique case (state_q)
      ST_SQ_RE:  begin mul_a = 48'(re_q);    mul_b = re_q;  need_mul = 1'b1; end
      ST_SQ_IM:  begin mul_a = 48'(im_q);    mul_b = im_q;  need_mul = 1'b1; end
      ST_LEVEL:  begin mul_a = 48'(comp_q);  mul_b = mag_q; need_mul = 1'b1; end
      ST_PEAK:   begin
        mul_a = 48'(peak_q); mul_b = GW'(meter_decay_q); need_mul = !peak_up;
      end
      ST_REDUCE: begin
        mul_a = 48'(rd_q); mul_b = GW'(disp_decay_q); need_mul = in_range && !red_up;
      end
      ST_EQ1:    begin mul_a = 48'(cmask_q); mul_b = pre_eq_q; need_mul = eq_en_q; end
      ST_EQ2:    begin mul_a = t_q;          mul_b = eq_q;     need_mul = 1'b1; end
      default: ;
    endcase
  end

  assign mul_start  = need_mul && !st_q;
  assign sqrt_start = (state_q == ST_ROOT) && !st_q;
  assign div_start  = (state_q == ST_DIVIDE) && !st_q && limit;

  scm_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  scm_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .rad_i(sq_q),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  scm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dvd_i(38'd1 << 37), .dvs_i(mag_q),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(idx_q);
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
    end else if (state_q == ST_REDUCE && in_range) begin
      if (!st_q && red_up) begin
        mem_we = 1'b1;
        mem_wd = red;
      end else if (st_q && mul_done) begin
        mem_we = 1'b1;
        mem_wd = decayed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[AW'(idx_q)];
  end

  assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      st_q     <= 1'b0;
      clr_q    <= '0;
      peak_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (mul_start || sqrt_start || div_start) begin
        st_q <= 1'b1;
      end
      if (m_axis_tready && !out_load) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NUM_BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx_q   <= s_axis_tdata[11:0];
            re_q    <= re_abs;
            im_q    <= im_abs;
            comp_q  <= s_axis_tdata[83:60];
            eq_q    <= s_axis_tdata[107:84];
            last_q  <= s_axis_tlast;
            state_q <= ST_SQ_RE;
          end
        end
        ST_SQ_RE: begin
          if (mul_done) begin
            sq_q    <= mul_p[scm_pkg::WideW-1:0];
            st_q    <= 1'b0;
            state_q <= ST_SQ_IM;
          end
        end
        ST_SQ_IM: begin
          if (mul_done) begin
            sq_q    <= sq_q + mul_p[scm_pkg::WideW-1:0];
            st_q    <= 1'b0;
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            mag_q   <= sqrt_root;
            st_q    <= 1'b0;
            state_q <= ST_LEVEL;
          end
        end
        ST_LEVEL: begin
          if (mul_done) begin
            level_q <= mul_p[scm_pkg::WideW-1:0];
            st_q    <= 1'b0;
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          // only a bin whose level is above unity is limited
          if (!limit) begin
            cmask_q <= comp_q;
            st_q    <= 1'b0;
            state_q <= ST_PEAK;
          end else if (div_done) begin
            cmask_q <= (|div_q[scm_pkg::QuotW-1:GW]) ? scm_pkg::Max24 : div_q[GW-1:0];
            st_q    <= 1'b0;
            state_q <= ST_PEAK;
          end
        end
        ST_PEAK: begin
          if (peak_up) begin
            peak_q  <= (|level_q[47:45]) ? scm_pkg::Max24 : level_q[44:21];
            st_q    <= 1'b0;
            state_q <= ST_REDUCE;
          end else if (st_q && mul_done) begin
            peak_q  <= decayed;
            st_q    <= 1'b0;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (!in_range) begin
            rpeak_q <= '0;
            state_q <= ST_EQ1;
          end else if (!st_q && red_up) begin
            rpeak_q <= red;
            state_q <= ST_EQ1;
          end else if (st_q && mul_done) begin
            rpeak_q <= decayed;
            st_q    <= 1'b0;
            state_q <= ST_EQ1;
          end
        end
        ST_EQ1: begin
          if (!eq_en_q) begin
            mask_q  <= cmask_q;
            state_q <= ST_OUT;
          end else if (mul_done) begin
            t_q     <= mul_p[scm_pkg::WideW-1:0];
            st_q    <= 1'b0;
            state_q <= ST_EQ2;
          end
        end
        ST_EQ2: begin
          if (mul_done) begin
            mask_q  <= (|eq_full[scm_pkg::ProdW-1:56]) ? scm_pkg::Max24
                                                       : eq_full[55:32];
            st_q    <= 1'b0;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q   <= idx_q;
      omask_q  <= mask_q;
      orpeak_q <= rpeak_q;
      opeak_q  <= peak_q;
      olast_q  <= last_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0, opeak_q, orpeak_q, omask_q, oidx_q};
  assign m_axis_tlast  = olast_q;

endmodule
`default_nettype wire

// ===== hdl/scm_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scm_mul
// Bit-serial shift-add multiplier, 48 x 24 bits, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module scm_mul (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [scm_pkg::WideW-1:0]       a_i,
  input  wire logic [scm_pkg::GainW-1:0]       b_i,
  output logic                                 done_o,
  output logic      [scm_pkg::ProdW-1:0]       prod_o
);

  logic [scm_pkg::ProdW-1:0] p_q;
  logic [scm_pkg::WideW-1:0] a_q;
  logic [4:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [scm_pkg::WideW:0]   sum;

  // partial sum on the upper half, multiplier bits shift out below
  assign sum = {1'b0, p_q[scm_pkg::ProdW-1:scm_pkg::GainW]}
             + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(scm_pkg::GainW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{scm_pkg::WideW{1'b0}}, b_i};
      a_q <= a_i;
    end else if (busy_q) begin
      p_q <= {sum, p_q[scm_pkg::GainW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule
`default_nettype wire

// ===== hdl/scm_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scm_sqrt
// Restoring integer square root of a 48-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
module scm_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [scm_pkg::WideW-1:0]     rad_i,
  output logic                               done_o,
  output logic      [scm_pkg::GainW-1:0]     root_o
);

  logic [scm_pkg::WideW-1:0] rad_q;
  logic [25:0]               rem_q;
  logic [scm_pkg::GainW-1:0] root_q;
  logic [4:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [26:0]               rem_sh, trial;

  assign rem_sh = {rem_q[24:0], rad_q[scm_pkg::WideW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(scm_pkg::GainW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[scm_pkg::WideW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 26'(rem_sh - trial);
        root_q <= {root_q[scm_pkg::GainW-2:0], 1'b1};
      end else begin
        rem_q  <= 26'(rem_sh);
        root_q <= {root_q[scm_pkg::GainW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== hdl/scm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scm_div
// Restoring divider, 38-bit dividend by 24-bit divisor, one quotient bit a
// cycle.
// ----------------------------------------------------------------------------
module scm_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [scm_pkg::QuotW-1:0]     dvd_i,
  input  wire logic [scm_pkg::GainW-1:0]     dvs_i,
  output logic                               done_o,
  output logic      [scm_pkg::QuotW-1:0]     quot_o
);

  logic [scm_pkg::QuotW-1:0] dvd_q, q_q;
  logic [scm_pkg::GainW-1:0] dvs_q, rem_q;
  logic [5:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [scm_pkg::GainW:0]   rem_sh;

  assign rem_sh = {rem_q, dvd_q[scm_pkg::QuotW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(scm_pkg::QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[scm_pkg::QuotW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= scm_pkg::GainW'(rem_sh - {1'b0, dvs_q});
        q_q   <= {q_q[scm_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[scm_pkg::GainW-1:0];
        q_q   <= {q_q[scm_pkg::QuotW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule
`default_nettype wire
